// ===== design/cest_pkg.sv =====
// Shared types and codes for the contact enter/stay/exit tracker.
package cest_pkg;

    // Width of the partner ID field on the ports
    localparam int unsigned ID_FIELD_W = 16;

    // Input word kinds (code 3 is ignored)
    typedef enum logic [1:0] {
        KIND_REPORT = 2'd0,
        KIND_FRAME  = 2'd1,
        KIND_DEACT  = 2'd2
    } t_kind;

    // Result event codes
    typedef enum logic [2:0] {
        EV_ENTER = 3'd0,
        EV_STAY  = 3'd1,
        EV_EXIT  = 3'd2,
        EV_DONE  = 3'd3,
        EV_FULL  = 3'd4
    } t_event;

    // Control sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_DONE
    } t_state;

    // Input word
    typedef struct packed {
        t_kind                   kind;
        logic [ID_FIELD_W-1:0]   partner_id;
        logic                    self_dead;
        logic                    partner_dead;
    } t_in_word;

    // Result word
    typedef struct packed {
        t_event                  event_res;
        logic [ID_FIELD_W-1:0]   event_partner;
        logic                    notify_partner;
        logic                    last;
    } t_out_word;

    // Per-cell command from the sequencer
    typedef struct packed {
        logic shift;   // ring rotate: take the neighbor's entry
        logic report;  // contact report lookup is being applied
        logic insert;  // this cell takes the new partner
        logic dead;    // either owner is dead
    } t_cell_cmd;

endpackage

// ===== design/contact_enter_stay_exit_tracker.sv =====
// Top level of the contact enter/stay/exit tracker: cell ring and sweep sequencer.
//
// A contact report is looked up in all cells at once and applied at the edge that
// accepts it; its result, if any, is on o_word with o_strobe in the next cycle, and a
// new report can be accepted every cycle while not busy. A frame-end or deactivate
// sweep rotates the ring of TABLE_DEPTH cells one entry per cycle past the head, so
// busy stays high while each entry passes the head, and then for the done word.
// Exit words come out in ascending table order, at most one per cycle, and the done
// word (last set) follows. Results cannot be held off: capture every strobed word.
module contact_enter_stay_exit_tracker #(
    parameter int unsigned TABLE_DEPTH = 16,
    parameter int unsigned ID_BITS     = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  cest_pkg::t_in_word   i_word,
    output logic                 o_strobe,
    output cest_pkg::t_out_word  o_word
);
    import cest_pkg::*;

    localparam int unsigned IdW  = (ID_BITS < ID_FIELD_W) ? ID_BITS : ID_FIELD_W;
    localparam int unsigned CntW = $clog2(TABLE_DEPTH);

    // Cell ring views
    logic [TABLE_DEPTH-1:0] w_valid, w_contact, w_seen, w_hit;
    logic [IdW-1:0]         w_partner [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] w_sh_valid, w_sh_contact, w_sh_seen;
    logic [IdW-1:0]         w_sh_partner [TABLE_DEPTH];
    t_cell_cmd              w_cmd [TABLE_DEPTH];

    // Lookup summary
    logic [IdW-1:0]         w_pid;
    logic                   w_dead;
    logic [TABLE_DEPTH-1:0] w_free_oh;
    logic                   w_full, w_hit_any, w_hit_contact;
    logic                   w_accept, w_report;

    // Head of the ring after sweep processing
    logic                   w_head_valid, w_head_contact, w_head_emit;

    // Sequencer registers
    t_state                 r_state, n_state;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic                   r_deact, n_deact;
    logic                   r_strobe, n_strobe;
    t_out_word              r_out, n_out;
    logic                   n_shift;

    assign w_pid    = i_word.partner_id[IdW-1:0];
    assign w_dead   = i_word.self_dead | i_word.partner_dead;
    assign busy     = (r_state != ST_IDLE);
    assign w_accept = start && !busy;
    assign w_report = w_accept && (i_word.kind == KIND_REPORT);

    // Lowest free entry as a one-hot; zero when the table is full
    assign w_free_oh     = ~w_valid & (w_valid + TABLE_DEPTH'(1));
    assign w_full        = &w_valid;
    assign w_hit_any     = |w_hit;
    assign w_hit_contact = |(w_hit & w_contact);

    // Cell row
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        assign w_cmd[g] = '{shift:  n_shift,
                            report: w_report,
                            insert: w_report && !w_hit_any && w_free_oh[g],
                            dead:   w_dead};

        if (g == TABLE_DEPTH - 1) begin : g_tail
            assign w_sh_valid[g]   = w_head_valid;
            assign w_sh_partner[g] = w_partner[0];
            assign w_sh_contact[g] = w_head_contact;
            assign w_sh_seen[g]    = 1'b0;
        end else begin : g_link
            assign w_sh_valid[g]   = w_valid[g+1];
            assign w_sh_partner[g] = w_partner[g+1];
            assign w_sh_contact[g] = w_contact[g+1];
            assign w_sh_seen[g]    = w_seen[g+1];
        end

        cest_cell #(
            .ID_W (IdW)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cmd        (w_cmd[g]),
            .i_pid        (w_pid),
            .i_sh_valid   (w_sh_valid[g]),
            .i_sh_partner (w_sh_partner[g]),
            .i_sh_contact (w_sh_contact[g]),
            .i_sh_seen    (w_sh_seen[g]),
            .o_valid      (w_valid[g]),
            .o_partner    (w_partner[g]),
            .o_contact    (w_contact[g]),
            .o_seen       (w_seen[g]),
            .o_hit        (w_hit[g])
        );
    end

    // Sweep step on the head entry; seen is always cleared on the way round
    always_comb begin
        w_head_valid   = w_valid[0];
        w_head_contact = w_contact[0];
        w_head_emit    = 1'b0;
        if (w_valid[0]) begin
            if (r_deact) begin
                if (w_contact[0]) begin
                    w_head_contact = 1'b0;
                    w_head_emit    = 1'b1;
                end
            end else if (!w_seen[0]) begin
                if (w_contact[0]) begin
                    w_head_contact = 1'b0;
                    w_head_emit    = 1'b1;
                end else begin
                    w_head_valid = 1'b0;
                end
            end
        end
    end

    // Sequencer: next state and result word
    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_deact  = r_deact;
        n_strobe = 1'b0;
        n_out    = '{event_res: EV_DONE, event_partner: '0,
                     notify_partner: 1'b0, last: 1'b1};
        n_shift  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_word.kind)
                        KIND_REPORT: begin
                            n_out.event_partner = ID_FIELD_W'(w_pid);
                            if (w_hit_any) begin
                                if (w_hit_contact) begin
                                    n_strobe        = 1'b1;
                                    n_out.event_res = w_dead ? EV_EXIT : EV_STAY;
                                end else if (!w_dead) begin
                                    n_strobe        = 1'b1;
                                    n_out.event_res = EV_ENTER;
                                end
                            end else begin
                                n_strobe        = 1'b1;
                                n_out.event_res = w_full ? EV_FULL : EV_ENTER;
                            end
                        end
                        KIND_FRAME: begin
                            n_state = ST_SWEEP;
                            n_cnt   = '0;
                            n_deact = 1'b0;
                        end
                        KIND_DEACT: begin
                            n_state = ST_SWEEP;
                            n_cnt   = '0;
                            n_deact = 1'b1;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_SWEEP: begin
                n_shift              = 1'b1;
                n_strobe             = w_head_emit;
                n_out.event_res      = EV_EXIT;
                n_out.event_partner  = ID_FIELD_W'(w_partner[0]);
                n_out.notify_partner = r_deact;
                n_out.last           = 1'b0;
                n_cnt                = r_cnt + CntW'(1);
                if (r_cnt == CntW'(TABLE_DEPTH - 1)) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                n_strobe = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
        end
    end

    // Payload and sweep bookkeeping, no reset
    always_ff @(posedge i_clk) begin
        r_cnt   <= n_cnt;
        r_deact <= n_deact;
        r_out   <= n_out;
    end

    assign o_strobe = r_strobe;
    assign o_word   = r_out;

`ifndef NO_ASSERTIONS
    // Partner IDs in the table are unique, so a lookup hits at most one cell
    a_hit_unique: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_hit))
        else $error("more than one cell matches the partner");

    // A report that finds a full table leaves the valid set alone
    a_full_no_insert: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_report && w_full && !w_hit_any |=> $stable(w_valid))
        else $error("insert on a full table");

    // The done step always delivers a done word with last set
    a_done_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DONE |=> o_strobe && o_word.event_res == EV_DONE
                               && o_word.last && r_state == ST_IDLE)
        else $error("sweep did not close with a done word");

    // During a sweep, every strobed word is an exit word with last clear
    a_sweep_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_SWEEP |=> !o_strobe || (o_word.event_res == EV_EXIT && !o_word.last))
        else $error("sweep produced a word other than exit");
`endif

endmodule

// ===== design/cest_cell.sv =====
// One table entry of the contact tracker ring: holds, matches and shifts its entry.
module cest_cell #(
    parameter int unsigned ID_W = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  cest_pkg::t_cell_cmd i_cmd,
    input  logic [ID_W-1:0]   i_pid,
    input  logic              i_sh_valid,
    input  logic [ID_W-1:0]   i_sh_partner,
    input  logic              i_sh_contact,
    input  logic              i_sh_seen,
    output logic              o_valid,
    output logic [ID_W-1:0]   o_partner,
    output logic              o_contact,
    output logic              o_seen,
    output logic              o_hit
);
    import cest_pkg::*;

    logic            r_valid, n_valid;
    logic [ID_W-1:0] r_partner, n_partner;
    logic            r_contact, n_contact;
    logic            r_seen, n_seen;

    // Match against the reported partner
    assign o_hit = r_valid && (r_partner == i_pid);

    // Entry update: rotate, insert, or lookup hit
    always_comb begin
        n_valid   = r_valid;
        n_partner = r_partner;
        n_contact = r_contact;
        n_seen    = r_seen;
        if (i_cmd.shift) begin
            n_valid   = i_sh_valid;
            n_partner = i_sh_partner;
            n_contact = i_sh_contact;
            n_seen    = i_sh_seen;
        end else if (i_cmd.insert) begin
            n_valid   = 1'b1;
            n_partner = i_pid;
            n_contact = 1'b1;
            n_seen    = 1'b1;
        end else if (i_cmd.report && o_hit) begin
            // stay/re-enter keep contact, a dead owner drops it
            n_seen    = 1'b1;
            n_contact = !i_cmd.dead;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        r_partner <= n_partner;
        r_contact <= n_contact;
        r_seen    <= n_seen;
    end

    assign o_valid   = r_valid;
    assign o_partner = r_partner;
    assign o_contact = r_contact;
    assign o_seen    = r_seen;

endmodule
